// ----- hdl/rrtt_pkg.sv -----
//------------------------------------------------------------------------------
// rrtt_pkg
// Shared types and constants for the round-robin task table.
//------------------------------------------------------------------------------
package rrtt_pkg;

	localparam int NUM_SLOTS_DEF = 16;

	typedef enum logic [2:0] {
		OP_CREATE = 3'd0,
		OP_TERM   = 3'd1,
		OP_SCHED  = 3'd2,
		OP_TICK   = 3'd3,
		OP_STATS  = 3'd4,
		OP_READ   = 3'd5
	} op_t;

	localparam logic [1:0] ST_TERM  = 2'd0;
	localparam logic [1:0] ST_READY = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_BLOCK = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	localparam logic [6:0] PCT_MAX = 7'd100;

endpackage

// ----- hdl/rrtt_ram.sv -----
//------------------------------------------------------------------------------
// rrtt_ram
// Generic single-port RAM with registered read data.
//------------------------------------------------------------------------------
module rrtt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, then register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- hdl/rrtt_div.sv -----
//------------------------------------------------------------------------------
// rrtt_div
// Restoring divider, one quotient bit per cycle, saturating percent result.
//------------------------------------------------------------------------------
module rrtt_div #(
	parameter int NW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [31:0]   den,
	output logic          done,
	output logic [6:0]    pct
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [32:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [32:0]   trial;

	assign trial = {rem_q[31:0], quo_q[NW-1]};

	// shift one numerator bit into the remainder per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= trial - {1'b0, den};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// saturate at one hundred
	assign pct = (quo_q > NW'(rrtt_pkg::PCT_MAX)) ? rrtt_pkg::PCT_MAX : quo_q[6:0];

endmodule

// ----- hdl/round_robin_task_table_top.sv -----
//------------------------------------------------------------------------------
// round_robin_task_table_top
// Task slot table with round-robin scheduler, tick accounting and statistics.
//------------------------------------------------------------------------------
// Usage: one input item (op, pid, priority_req, tick_ms) on in_valid/in_stall
// yields exactly one result item on out_valid/out_stall. in_stall is high
// while an item is in progress or a result waits to be taken.
// Create, stats, schedule and tick items walk the slot table through one
// shared slot pointer, one slot per cycle, with the runtime RAM read
// registered. Create stops at the first free slot; terminate reschedules
// only when the running slot goes; read goes through the registered RAM
// read. Tick reads the running slot, walks the sum of run times, then runs
// a bit-serial divide of the busy sum times 100 by the uptime, skipped at
// zero uptime. After the result leaves, the sequencer returns to idle and
// takes the next item from there. Reset clears state bits and the slot
// valid flags at once: slot 0 becomes the running idle task, all other
// slots terminated; RAM words of slots not yet written read as zero through
// a written flag per slot. While the receiver stalls, the result holds in
// the output registers and no new item is taken.
//------------------------------------------------------------------------------
module round_robin_task_table_top #(
	parameter int NUM_SLOTS = rrtt_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [3:0]  pid,
	input  logic [7:0]  priority_req,
	input  logic [15:0] tick_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  slot,
	output logic [3:0]  current_slot,
	output logic [1:0]  entry_state,
	output logic [7:0]  entry_priority,
	output logic [31:0] entry_runtime,
	output logic [31:0] entry_created,
	output logic [6:0]  busy_percent,
	output logic [31:0] uptime,
	output logic [4:0]  running_count,
	output logic [4:0]  ready_count,
	output logic [4:0]  blocked_count
);

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int NW = 32 + SW + 7;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_FIND  = 8'b00000010,
		S_SCHED = 8'b00000100,
		S_RD    = 8'b00001000,
		S_RDW   = 8'b00010000,
		S_SUM   = 8'b00100000,
		S_DIV   = 8'b01000000,
		S_OUT   = 8'b10000000
	} fsm_t;

	fsm_t fsm_q;

	logic [1:0]    state_q [NUM_SLOTS];
	logic          wr_q [NUM_SLOTS];
	logic [7:0]    prio_q [NUM_SLOTS];
	logic [SW-1:0] run_q;
	logic [31:0]   up_q;
	logic [6:0]    pct_q;

	logic [2:0]    op_q;
	logic [3:0]    pid_q;
	logic [7:0]    preq_q;
	logic [15:0]   ms_q;
	logic [SW-1:0] ptr_q;
	logic [CW-1:0] step_q;
	logic          found_q;
	logic [SW-1:0] hit_q;
	logic [CW-1:0] nr_q, nd_q, nb_q;
	logic [NW-1:0] sum_q;
	logic          rdv_q;
	logic [SW-1:0] rdp_q;

	// shared RAM port for runtime and creation words
	logic          rt_we, cr_we;
	logic [SW-1:0] ram_addr;
	logic [31:0]   rt_wd, cr_wd, rt_rd, cr_rd;

	logic          div_start, div_done;
	logic [6:0]    div_pct;

	logic          pid_ok;
	logic [SW-1:0] pid_ix;
	logic [31:0]   rt_eff;
	logic [SW-1:0] run_nxt;

	assign pid_ok  = (32'(pid) < 32'(NUM_SLOTS));
	assign pid_ix  = SW'(pid_q);
	assign rt_eff  = wr_q[rdp_q] ? rt_rd : 32'd0;
	assign run_nxt = (32'(run_q) == NUM_SLOTS - 1) ? '0 : run_q + 1'b1;

	rrtt_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_rt (
		.clk(clk), .we(rt_we), .addr(ram_addr), .wdata(rt_wd), .rdata(rt_rd)
	);
	rrtt_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_cr (
		.clk(clk), .we(cr_we), .addr(ram_addr), .wdata(cr_wd), .rdata(cr_rd)
	);

	rrtt_div #(.NW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(sum_q * NW'(100)), .den(up_q), .done(div_done), .pct(div_pct)
	);

	// RAM port control
	always_comb begin
		rt_we    = 1'b0;
		cr_we    = 1'b0;
		rt_wd    = 32'd0;
		cr_wd    = up_q;
		ram_addr = ptr_q;
		if (fsm_q == S_FIND && op_q == rrtt_pkg::OP_CREATE
		    && state_q[ptr_q] == rrtt_pkg::ST_TERM) begin
			rt_we = 1'b1;
			cr_we = 1'b1;
		end else if (fsm_q == S_RDW && rdv_q && op_q == rrtt_pkg::OP_TICK) begin
			ram_addr = rdp_q;
			rt_we    = 1'b1;
			rt_wd    = rt_eff + 32'(ms_q);
			// first write of a never-created slot: zero its creation word too
			cr_we    = !wr_q[rdp_q];
			cr_wd    = 32'd0;
		end else if (fsm_q == S_RD) begin
			ram_addr = (op_q == rrtt_pkg::OP_READ) ? pid_ix : run_q;
		end
	end

	assign div_start = (fsm_q == S_DIV) && (step_q == CW'(NUM_SLOTS));
	assign in_stall  = (fsm_q != S_IDLE);

	// sequencer: one slot per cycle through the shared pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= S_IDLE;
			out_valid <= 1'b0;
			run_q     <= '0;
			up_q      <= '0;
			pct_q     <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				state_q[i] <= (i == 0) ? rrtt_pkg::ST_RUN : rrtt_pkg::ST_TERM;
				wr_q[i]    <= 1'b0;
				prio_q[i]  <= 8'd0;
			end
		end else begin
			unique case (fsm_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						pid_q   <= pid;
						preq_q  <= priority_req;
						ms_q    <= tick_ms;
						ptr_q   <= '0;
						step_q  <= '0;
						found_q <= 1'b0;
						nr_q    <= '0;
						nd_q    <= '0;
						nb_q    <= '0;
						sum_q   <= '0;
						rdv_q   <= 1'b0;
						status        <= rrtt_pkg::STAT_OK;
						slot          <= 4'd0;
						entry_state   <= 2'd0;
						entry_priority <= 8'd0;
						entry_runtime <= 32'd0;
						entry_created <= 32'd0;
						running_count <= 5'd0;
						ready_count   <= 5'd0;
						blocked_count <= 5'd0;
						unique case (op)
							rrtt_pkg::OP_CREATE, rrtt_pkg::OP_STATS: fsm_q <= S_FIND;
							rrtt_pkg::OP_SCHED: begin
								ptr_q <= run_nxt;
								fsm_q <= S_SCHED;
							end
							rrtt_pkg::OP_TERM: begin
								if (!pid_ok || state_q[SW'(pid)] == rrtt_pkg::ST_TERM) begin
									status <= rrtt_pkg::STAT_BAD;
									fsm_q  <= S_OUT;
								end else begin
									state_q[SW'(pid)] <= rrtt_pkg::ST_TERM;
									if (SW'(pid) == run_q) begin
										ptr_q <= run_nxt;
										fsm_q <= S_SCHED;
									end else begin
										fsm_q <= S_OUT;
									end
								end
							end
							rrtt_pkg::OP_TICK: begin
								up_q  <= up_q + 32'(tick_ms);
								rdv_q <= (state_q[run_q] == rrtt_pkg::ST_RUN);
								rdp_q <= run_q;
								fsm_q <= S_RD;
							end
							rrtt_pkg::OP_READ: begin
								if (pid_ok) begin
									rdp_q <= SW'(pid);
									fsm_q <= S_RD;
								end else begin
									status <= rrtt_pkg::STAT_BAD;
									fsm_q  <= S_OUT;
								end
							end
							default: fsm_q <= S_OUT;
						endcase
					end
				end
				S_FIND: begin
					// create: claim first terminated slot; stats: count states
					if (op_q == rrtt_pkg::OP_CREATE) begin
						if (state_q[ptr_q] == rrtt_pkg::ST_TERM) begin
							state_q[ptr_q] <= rrtt_pkg::ST_READY;
							prio_q[ptr_q]  <= preq_q;
							wr_q[ptr_q]    <= 1'b1;
							slot  <= 4'(ptr_q);
							fsm_q <= S_OUT;
						end
					end else begin
						unique case (state_q[ptr_q])
							rrtt_pkg::ST_RUN:   nr_q <= nr_q + 1'b1;
							rrtt_pkg::ST_READY: nd_q <= nd_q + 1'b1;
							rrtt_pkg::ST_BLOCK: nb_q <= nb_q + 1'b1;
							default: ;
						endcase
					end
					ptr_q  <= ptr_q + 1'b1;
					step_q <= step_q + 1'b1;
					if (step_q == CW'(NUM_SLOTS - 1)) begin
						fsm_q <= S_OUT;
						if (op_q == rrtt_pkg::OP_CREATE
						    && state_q[ptr_q] != rrtt_pkg::ST_TERM) begin
							status <= rrtt_pkg::STAT_FULL;
						end
						if (op_q == rrtt_pkg::OP_STATS) begin
							running_count <= 5'(nr_q + CW'(state_q[ptr_q] == rrtt_pkg::ST_RUN));
							ready_count   <= 5'(nd_q + CW'(state_q[ptr_q] == rrtt_pkg::ST_READY));
							blocked_count <= 5'(nb_q + CW'(state_q[ptr_q] == rrtt_pkg::ST_BLOCK));
						end
					end
				end
				S_SCHED: begin
					// walk from running+1 for a ready slot, then commit
					if (step_q == CW'(NUM_SLOTS)) begin
						if (found_q) begin
							if (hit_q != run_q && state_q[run_q] == rrtt_pkg::ST_RUN)
								state_q[run_q] <= rrtt_pkg::ST_READY;
							state_q[hit_q] <= rrtt_pkg::ST_RUN;
							run_q <= hit_q;
						end else begin
							if (run_q != '0 && state_q[run_q] == rrtt_pkg::ST_RUN)
								state_q[run_q] <= rrtt_pkg::ST_READY;
							state_q[0] <= rrtt_pkg::ST_RUN;
							run_q <= '0;
						end
						fsm_q <= S_OUT;
					end else begin
						if (!found_q && state_q[ptr_q] == rrtt_pkg::ST_READY) begin
							found_q <= 1'b1;
							hit_q   <= ptr_q;
						end
						ptr_q  <= (32'(ptr_q) == NUM_SLOTS - 1) ? '0 : ptr_q + 1'b1;
						step_q <= step_q + 1'b1;
					end
				end
				S_RD: begin
					// RAM read in flight
					fsm_q <= S_RDW;
				end
				S_RDW: begin
					if (op_q == rrtt_pkg::OP_READ) begin
						slot           <= pid_q;
						entry_state    <= state_q[rdp_q];
						entry_priority <= prio_q[rdp_q];
						entry_runtime  <= rt_eff;
						entry_created  <= wr_q[rdp_q] ? cr_rd : 32'd0;
						fsm_q <= S_OUT;
					end else begin
						if (rdv_q) wr_q[rdp_q] <= 1'b1;
						ptr_q <= '0;
						fsm_q <= S_SUM;
					end
				end
				S_SUM: begin
					// accumulate run time of live non-idle slots; read data lags one slot
					if (step_q >= CW'(2) && state_q[SW'(step_q - CW'(1))] != rrtt_pkg::ST_TERM
					    && wr_q[SW'(step_q - CW'(1))])
						sum_q <= sum_q + NW'(rt_rd);
					if (step_q == CW'(NUM_SLOTS)) begin
						if (up_q == 32'd0) begin
							pct_q <= '0;
							fsm_q <= S_OUT;
						end else begin
							fsm_q <= S_DIV;
						end
					end else begin
						step_q <= step_q + 1'b1;
						if (step_q != CW'(NUM_SLOTS - 1))
							ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DIV: begin
					// start pulse on the first cycle, then wait for the quotient
					step_q <= '0;
					if (div_done) begin
						pct_q <= div_pct;
						fsm_q <= S_OUT;
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					if (out_valid && !out_stall) begin
						out_valid <= 1'b0;
						fsm_q     <= S_IDLE;
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	assign current_slot = 4'(run_q);
	assign busy_percent = pct_q;
	assign uptime       = up_q;

endmodule

// ----- bench/round_robin_task_table_top_tb.sv -----
//------------------------------------------------------------------------------
// round_robin_task_table_top_tb
// Drives create, terminate, schedule, tick, stats, read and unused operations,
// then checks every result field against a predicted copy of the task table.
//------------------------------------------------------------------------------
module round_robin_task_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 1040;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [3:0]  current_slot;
		logic [1:0]  entry_state;
		logic [7:0]  entry_priority;
		logic [31:0] entry_runtime;
		logic [31:0] entry_created;
		logic [6:0]  busy_percent;
		logic [31:0] uptime;
		logic [4:0]  running_count;
		logic [4:0]  ready_count;
		logic [4:0]  blocked_count;
	} task_result_t;

	// Task table mirror and queue of predicted results
	class task_table_scoreboard;
		logic [1:0]  slot_st[16];
		logic [7:0]  slot_pri[16];
		logic [31:0] slot_rt[16];
		logic [31:0] slot_born[16];
		logic [3:0]  cur;
		logic [31:0] up_ms;
		logic [6:0]  pct;
		task_result_t pending[$];
		int mismatches;
		int results_seen;

		function new();
			for (int i = 0; i < 16; i++) begin
				slot_st[i] = rrtt_pkg::ST_TERM;
				slot_pri[i] = '0;
				slot_rt[i] = '0;
				slot_born[i] = '0;
			end
			slot_st[0] = rrtt_pkg::ST_RUN;
			cur = '0;
			up_ms = '0;
			pct = '0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		// Round-robin pick after the running slot, idle slot as fallback
		function void reschedule();
			logic [3:0] nxt;
			bit found;
			nxt = cur;
			found = 0;
			for (int i = 0; i < 16; i++) begin
				if (!found) begin
					nxt = nxt + 4'd1;
					if (slot_st[nxt] == rrtt_pkg::ST_READY)
						found = 1;
				end
			end
			if (!found)
				nxt = '0;
			if (nxt != cur && slot_st[cur] == rrtt_pkg::ST_RUN)
				slot_st[cur] = rrtt_pkg::ST_READY;
			cur = nxt;
			slot_st[cur] = rrtt_pkg::ST_RUN;
		endfunction

		// Advance time and recompute busy share of live non-idle slots
		function void advance(logic [15:0] ms);
			longint unsigned busy_sum;
			longint unsigned q;
			busy_sum = 0;
			up_ms = up_ms + 32'(ms);
			if (slot_st[cur] == rrtt_pkg::ST_RUN)
				slot_rt[cur] = slot_rt[cur] + 32'(ms);
			for (int i = 1; i < 16; i++)
				if (slot_st[i] != rrtt_pkg::ST_TERM)
					busy_sum += 64'(slot_rt[i]);
			if (up_ms != 0) begin
				q = (busy_sum * 64'd100) / 64'(up_ms);
				pct = (q > 64'd100) ? rrtt_pkg::PCT_MAX : q[6:0];
			end else begin
				pct = '0;
			end
		endfunction

		function void note_item(logic [2:0] op_v, logic [3:0] pid_v,
				logic [7:0] pri_v, logic [15:0] ms_v);
			task_result_t r;
			bit found;
			r = '0;
			found = 0;
			case (op_v)
				rrtt_pkg::OP_CREATE: begin
					for (int i = 0; i < 16; i++) begin
						if (!found && slot_st[i] == rrtt_pkg::ST_TERM) begin
							found = 1;
							slot_st[i] = rrtt_pkg::ST_READY;
							slot_pri[i] = pri_v;
							slot_rt[i] = '0;
							slot_born[i] = up_ms;
							r.slot = i[3:0];
						end
					end
					if (!found)
						r.status = rrtt_pkg::STAT_FULL;
				end
				rrtt_pkg::OP_TERM: begin
					if (slot_st[pid_v] == rrtt_pkg::ST_TERM) begin
						r.status = rrtt_pkg::STAT_BAD;
					end else begin
						slot_st[pid_v] = rrtt_pkg::ST_TERM;
						if (pid_v == cur)
							reschedule();
					end
				end
				rrtt_pkg::OP_SCHED: reschedule();
				rrtt_pkg::OP_TICK: advance(ms_v);
				rrtt_pkg::OP_STATS: begin
					for (int i = 0; i < 16; i++) begin
						if (slot_st[i] == rrtt_pkg::ST_RUN)
							r.running_count++;
						else if (slot_st[i] == rrtt_pkg::ST_READY)
							r.ready_count++;
						else if (slot_st[i] == rrtt_pkg::ST_BLOCK)
							r.blocked_count++;
					end
				end
				rrtt_pkg::OP_READ: begin
					r.slot = pid_v;
					r.entry_state = slot_st[pid_v];
					r.entry_priority = slot_pri[pid_v];
					r.entry_runtime = slot_rt[pid_v];
					r.entry_created = slot_born[pid_v];
				end
				default: ;
			endcase
			r.current_slot = cur;
			r.busy_percent = pct;
			r.uptime = up_ms;
			pending.push_back(r);
		endfunction

		function void check_result(task_result_t got);
			task_result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing pending: %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch on result %0d", results_seen);
					$display("  expected %p", want);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [3:0]  pid;
	logic [7:0]  priority_req;
	logic [15:0] tick_ms;
	logic        out_valid;
	logic        out_stall;
	task_result_t res;

	task_table_scoreboard table_sb;
	bit quiet_stretch;
	int op_count[8];
	int items_sent;

	round_robin_task_table_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.pid            (pid),
		.priority_req   (priority_req),
		.tick_ms        (tick_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (res.status),
		.slot           (res.slot),
		.current_slot   (res.current_slot),
		.entry_state    (res.entry_state),
		.entry_priority (res.entry_priority),
		.entry_runtime  (res.entry_runtime),
		.entry_created  (res.entry_created),
		.busy_percent   (res.busy_percent),
		.uptime         (res.uptime),
		.running_count  (res.running_count),
		.ready_count    (res.ready_count),
		.blocked_count  (res.blocked_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Present one item, with a random gap first, and hold it until taken
	task send_item(logic [2:0] op_v, logic [3:0] pid_v, logic [7:0] pri_v,
			logic [15:0] ms_v);
		while (!quiet_stretch && $urandom_range(99) < 12) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= op_v;
		pid <= pid_v;
		priority_req <= pri_v;
		tick_ms <= ms_v;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		table_sb.note_item(op_v, pid_v, pri_v, ms_v);
		op_count[op_v]++;
		items_sent++;
	endtask

	// Short or random ticks, sometimes zero or the largest step
	function logic [15:0] pick_ms();
		int k;
		k = $urandom_range(99);
		if (k < 10)
			return 16'h0000;
		if (k < 20)
			return 16'hffff;
		if (k < 60)
			return 16'($urandom_range(50));
		return 16'($urandom);
	endfunction

	task send_random();
		int k;
		k = $urandom_range(99);
		if (k < 20)
			send_item(rrtt_pkg::OP_CREATE, 4'($urandom), 8'($urandom), 16'($urandom));
		else if (k < 35)
			send_item(rrtt_pkg::OP_TERM, 4'($urandom), 8'($urandom), 16'($urandom));
		else if (k < 55)
			send_item(rrtt_pkg::OP_SCHED, 4'($urandom), 8'($urandom), 16'($urandom));
		else if (k < 75)
			send_item(rrtt_pkg::OP_TICK, 4'($urandom), 8'($urandom), pick_ms());
		else if (k < 83)
			send_item(rrtt_pkg::OP_STATS, 4'($urandom), 8'($urandom), 16'($urandom));
		else if (k < 97)
			send_item(rrtt_pkg::OP_READ, 4'($urandom), 8'($urandom), 16'($urandom));
		else if (k < 99)
			send_item(OP_SPARE_LO, 4'($urandom), 8'($urandom), 16'($urandom));
		else
			send_item(OP_SPARE_HI, 4'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// Take results with random stalls and check each one
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= !quiet_stretch && ($urandom_range(99) < 12);
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				table_sb.check_result(res);
		end
	end

	initial begin
		#20ms;
		$display("[round_robin_task_table_top] ERROR");
		$finish;
	end

	initial begin
		table_sb = new();
		quiet_stretch = 0;
		items_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = rrtt_pkg::OP_STATS;
		pid = '0;
		priority_req = '0;
		tick_ms = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle reads, zero-uptime tick, fill the table, overflow
		send_item(rrtt_pkg::OP_READ, 4'd0, 8'h00, 16'h0000);
		send_item(rrtt_pkg::OP_TICK, 4'd0, 8'h00, 16'h0000);
		send_item(rrtt_pkg::OP_TERM, 4'd15, 8'h00, 16'h0000);
		for (int i = 1; i < 16; i++)
			send_item(rrtt_pkg::OP_CREATE, 4'hf, (i == 1) ? 8'h00 : 8'hff, 16'hffff);
		send_item(rrtt_pkg::OP_CREATE, 4'd0, 8'h5a, 16'h0000);
		send_item(rrtt_pkg::OP_SCHED, 4'd0, 8'h00, 16'h0000);
		send_item(rrtt_pkg::OP_TICK, 4'hf, 8'hff, 16'hffff);
		send_item(rrtt_pkg::OP_STATS, 4'd0, 8'h00, 16'h0000);
		send_item(rrtt_pkg::OP_READ, 4'd15, 8'h00, 16'h0000);
		// Terminating the running slot reschedules; a second attempt is rejected
		send_item(rrtt_pkg::OP_TERM, 4'd1, 8'h00, 16'h0000);
		send_item(rrtt_pkg::OP_TERM, 4'd1, 8'h00, 16'h0000);
		send_item(rrtt_pkg::OP_TERM, 4'd0, 8'h00, 16'h0000);
		send_item(OP_SPARE_LO, 4'hf, 8'hff, 16'hffff);
		send_item(OP_SPARE_HI, 4'hf, 8'hff, 16'hffff);

		// Random operations, with one stretch free of gaps and stalls
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet_stretch = (n >= 400 && n < 650);
			send_random();
			// Occasionally empty the table so that a schedule falls back to slot 0
			if ($urandom_range(199) == 0)
				for (int s = 0; s < 16; s++)
					send_item(rrtt_pkg::OP_TERM, s[3:0], 8'($urandom), 16'($urandom));
		end
		quiet_stretch = 0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (table_sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("run covered %0d items: create %0d, terminate %0d, schedule %0d,",
			items_sent, op_count[rrtt_pkg::OP_CREATE], op_count[rrtt_pkg::OP_TERM],
			op_count[rrtt_pkg::OP_SCHED]);
		$display("  tick %0d, stats %0d, read %0d, unused codes %0d; %0d mismatches",
			op_count[rrtt_pkg::OP_TICK], op_count[rrtt_pkg::OP_STATS],
			op_count[rrtt_pkg::OP_READ],
			op_count[OP_SPARE_LO] + op_count[OP_SPARE_HI], table_sb.mismatches);
		if (table_sb.mismatches == 0 && table_sb.pending.size() == 0)
			$display("[round_robin_task_table_top] OK");
		else
			$display("[round_robin_task_table_top] ERROR");
		$finish;
	end

endmodule
